[rtl/ssq_pkg.sv]
`default_nettype none

package ssq_pkg;

  // fixed field widths of one beat
  localparam int TAG_W   = 16;
  localparam int AGE_W   = 8;
  localparam int PRIO_W  = 4;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 8;

  // defaults for the top level parameters
  localparam int DEPTH_DEFAULT     = 128;
  localparam int PRIO_BITS_DEFAULT = 4;

  // operation codes on the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // status codes on the result
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // record fields that do not depend on the priority width
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } payload_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/ssq_if.sv]
`default_nettype none

// request channel: one operation per beat
interface ssq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ssq_pkg::TAG_W-1:0]  tag_in;
  logic [ssq_pkg::AGE_W-1:0]  age_in;
  logic [ssq_pkg::PRIO_W-1:0] prio_in;

  modport source (output valid, mode, tag_in, age_in, prio_in, input ready);
  modport sink   (input valid, mode, tag_in, age_in, prio_in, output ready);
endinterface

// response channel: one result per beat
interface ssq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ssq_pkg::STAT_W-1:0] status;
  logic [ssq_pkg::TAG_W-1:0]  tag_out;
  logic [ssq_pkg::AGE_W-1:0]  age_out;
  logic [ssq_pkg::PRIO_W-1:0] prio_out;
  logic [ssq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, status, tag_out, age_out, prio_out, occupancy,
                  input ready);
  modport sink   (input valid, status, tag_out, age_out, prio_out, occupancy,
                  output ready);
endinterface

`default_nettype wire

[rtl/ssq_cell.sv]
`default_nettype none

module ssq_cell #(
  parameter int PRIO_BITS = ssq_pkg::PRIO_BITS_DEFAULT
) (
  input  wire                      clk,
  input  wire ssq_pkg::cell_ctrl_t ctrl,
  input  wire                      occ,
  input  wire                      left_gt,
  input  wire ssq_pkg::payload_t   new_pl,
  input  wire [PRIO_BITS-1:0]      new_prio,
  input  wire ssq_pkg::payload_t   left_pl,
  input  wire [PRIO_BITS-1:0]      left_prio,
  input  wire ssq_pkg::payload_t   right_pl,
  input  wire [PRIO_BITS-1:0]      right_prio,
  output ssq_pkg::payload_t        pl,
  output logic [PRIO_BITS-1:0]     prio,
  output logic                     gt
);

  // held record ranks behind the incoming one
  assign gt = occ && (prio > new_prio);

  // insert shifts down behind the new record, remove shifts up
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_gt) begin
        pl   <= left_pl;
        prio <= left_prio;
      end else if (gt || !occ) begin
        pl   <= new_pl;
        prio <= new_prio;
      end
    end else if (ctrl.rem) begin
      pl   <= right_pl;
      prio <= right_prio;
    end
  end

endmodule

`default_nettype wire

[rtl/stable_sorted_priority_queue.sv]
`default_nettype none

// channel | dir | fields                                        | handshake
// req     | in  | mode, tag_in, age_in, prio_in                 | valid/ready
// rsp     | out | status, tag_out, age_out, prio_out, occupancy | valid/ready
//
// one operation per cycle: every cell compares its priority with the new one
// in parallel and loads from a neighbor or the new record: no per-item loop
// the result lands in the output register in the cycle after the request beat
// a new request is taken whenever that register is empty or being drained
// rst is synchronous; it clears the fill count and the output valid only
// stalls on rsp hold the result and back-pressure req

module stable_sorted_priority_queue #(
  parameter int DEPTH     = ssq_pkg::DEPTH_DEFAULT,
  parameter int PRIO_BITS = ssq_pkg::PRIO_BITS_DEFAULT
) (
  input wire        clk,
  input wire        rst,
  ssq_req_if.sink   req,
  ssq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 take;
  logic                 full;
  logic                 empty;
  ssq_pkg::cell_ctrl_t  ctrl;
  ssq_pkg::payload_t    new_pl;
  logic [PRIO_BITS-1:0] new_prio;

  ssq_pkg::payload_t    pl   [DEPTH];
  logic [PRIO_BITS-1:0] prio [DEPTH];
  logic [DEPTH-1:0]     gt;
  logic [DEPTH-1:0]     occ;

  // output register frees up as it drains
  assign req.ready = !rsp.valid || rsp.ready;
  assign take      = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign ctrl.ins  = take && (req.mode == ssq_pkg::MODE_INSERT) && !full;
  assign ctrl.rem  = take && (req.mode == ssq_pkg::MODE_REMOVE) && !empty;
  assign new_pl    = '{tag: req.tag_in, age: req.age_in};
  assign new_prio  = PRIO_BITS'(req.prio_in);

  // fill count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0 && DEPTH > 1) begin : g_head
      ssq_cell #(.PRIO_BITS(PRIO_BITS)) u_cell (
        .clk(clk), .ctrl(ctrl), .occ(occ[i]), .left_gt(1'b0),
        .new_pl(new_pl), .new_prio(new_prio),
        .left_pl(new_pl), .left_prio(new_prio),
        .right_pl(pl[i+1]), .right_prio(prio[i+1]),
        .pl(pl[i]), .prio(prio[i]), .gt(gt[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      ssq_cell #(.PRIO_BITS(PRIO_BITS)) u_cell (
        .clk(clk), .ctrl(ctrl), .occ(occ[i]), .left_gt(gt[i-1]),
        .new_pl(new_pl), .new_prio(new_prio),
        .left_pl(pl[i-1]), .left_prio(prio[i-1]),
        .right_pl(pl[i]), .right_prio(prio[i]),
        .pl(pl[i]), .prio(prio[i]), .gt(gt[i])
      );
    end else begin : g_mid
      ssq_cell #(.PRIO_BITS(PRIO_BITS)) u_cell (
        .clk(clk), .ctrl(ctrl), .occ(occ[i]), .left_gt(gt[i-1]),
        .new_pl(new_pl), .new_prio(new_prio),
        .left_pl(pl[i-1]), .left_prio(prio[i-1]),
        .right_pl(pl[i+1]), .right_prio(prio[i+1]),
        .pl(pl[i]), .prio(prio[i]), .gt(gt[i])
      );
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req.ready) begin
      rsp.valid <= req.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      rsp.occupancy <= ssq_pkg::OCC_W'(count_next);
      if (ctrl.rem) begin
        rsp.status   <= ssq_pkg::ST_REMOVED;
        rsp.tag_out  <= pl[0].tag;
        rsp.age_out  <= pl[0].age;
        rsp.prio_out <= ssq_pkg::PRIO_W'(prio[0]);
      end else begin
        rsp.tag_out  <= '0;
        rsp.age_out  <= '0;
        rsp.prio_out <= '0;
        if (req.mode == ssq_pkg::MODE_REMOVE) begin
          rsp.status <= ssq_pkg::ST_EMPTY;
        end else if (full) begin
          rsp.status <= ssq_pkg::ST_FULL;
        end else begin
          rsp.status <= ssq_pkg::ST_INSERTED;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ssq_checker.sv]
`default_nettype none

module ssq_checker #(
  parameter int DEPTH = ssq_pkg::DEPTH_DEFAULT
) (
  input wire                       clk,
  input wire                       rst,
  input wire                       rsp_valid,
  input wire                       rsp_ready,
  input wire [ssq_pkg::STAT_W-1:0] status,
  input wire [ssq_pkg::TAG_W-1:0]  tag_out,
  input wire [ssq_pkg::AGE_W-1:0]  age_out,
  input wire [ssq_pkg::PRIO_W-1:0] prio_out,
  input wire [ssq_pkg::OCC_W-1:0]  occupancy
);

  localparam bit OCC_FITS = (DEPTH < (1 << ssq_pkg::OCC_W));

  // reset empties the output register
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(tag_out))
    else $error("stalled result changed");

  // only a real remove carries a record
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ssq_pkg::ST_REMOVED
      |-> tag_out == '0 && age_out == '0 && prio_out == '0)
    else $error("record fields set on a non-remove result");

  // occupancy never exceeds the queue depth
  a_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && OCC_FITS |-> occupancy <= ssq_pkg::OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  // a dropped insert only happens when the queue is full
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ssq_pkg::ST_FULL && OCC_FITS
      |-> occupancy == ssq_pkg::OCC_W'(DEPTH))
    else $error("insert dropped below depth");

endmodule

bind stable_sorted_priority_queue ssq_checker #(.DEPTH(DEPTH)) u_ssq_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .tag_out(rsp.tag_out), .age_out(rsp.age_out),
  .prio_out(rsp.prio_out), .occupancy(rsp.occupancy)
);

`default_nettype wire
